/* hw/rtl/sip24_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip24_pkg
// Shared types, constants, key-lane setup and the SipRound function for the
// SipHash-2-4 stream hasher.
// ----------------------------------------------------------------------------
package sip24_pkg;

    // SipHash initialization constants
    localparam logic [63:0] IV0       = 64'h736f_6d65_7073_6575;
    localparam logic [63:0] IV1       = 64'h646f_7261_6e64_6f6d;
    localparam logic [63:0] IV2       = 64'h6c79_6765_6e65_7261;
    localparam logic [63:0] IV3       = 64'h7465_6462_7974_6573;
    localparam logic [63:0] FINAL_XOR = 64'h0000_0000_0000_00ff;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W          = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

    // Front-to-back queue depth (default)
    localparam int unsigned QUEUE_DEPTH = 2;

    // Finalization runs four rounds, counted 0..3
    localparam logic [1:0] FIN_LAST = 2'd3;

    // Full-word byte count
    localparam logic [3:0] FULL_BYTES = 4'd8;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_lanes;

    // One classified request for the back end
    typedef struct packed {
        logic [63:0] data;  // full word to absorb
        logic [63:0] tail;  // length block (last request only)
        logic        load;  // first request of a message: reload lanes from key
        logic        full;  // data word is absorbed
        logic        last;  // tail is absorbed, then finalization
    } t_entry;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_ABS,
        BE_TAIL,
        BE_FIN
    } t_be_state;

    function automatic t_lanes key_lanes(input logic [63:0] k0, input logic [63:0] k1);
        t_lanes v;
        v.a = IV0 ^ k0;
        v.b = IV1 ^ k1;
        v.c = IV2 ^ k0;
        v.d = IV3 ^ k1;
        return v;
    endfunction

    function automatic t_lanes sip_round(input t_lanes v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        t_lanes      r;
        a = v.a;
        b = v.b;
        c = v.c;
        d = v.d;
        a = a + b;
        b = {b[50:0], b[63:51]};
        b = b ^ a;
        a = {a[31:0], a[63:32]};
        c = c + d;
        d = {d[47:0], d[63:48]};
        d = d ^ c;
        a = a + d;
        d = {d[42:0], d[63:43]};
        d = d ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]};
        b = b ^ c;
        c = {c[31:0], c[63:32]};
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

endpackage

/* hw/rtl/siphash_2_4_stream_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_2_4_stream_top
// Keyed SipHash-2-4 over a byte message streamed as 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one message word per request, little-endian bytes in
//   tdata[63:0], valid byte count in tdata[67:64] (8 unless tlast), tlast on
//   the final word. Master stream: one 64-bit tag per message.
//   Key halves are written through the config port (index 0 low, 1 high)
//   while the block is idle; a new key applies from the next message.
// Timing:
//   The engine runs one SipRound per cycle unless a waiting tag holds it. A
//   full word is absorbed by its compression rounds; a partial last word
//   takes the tail block plus four finalization rounds; a full last word
//   takes its own compression, then the length block and the four rounds.
//   The tag register loads at the end of the last round. A request queue
//   (QUEUE_DEPTH entries) lets the input side keep accepting while the
//   engine works or the output waits.
// Reset: synchronous, active low; keys clear to zero, queue and engine empty.
// Stall: a waiting tag holds the engine in its last finalization round; the
//   input side stalls only once the queue is full.
// ----------------------------------------------------------------------------
module siphash_2_4_stream_top #(
    parameter int unsigned QUEUE_DEPTH = sip24_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [sip24_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [63:0]                      i_cfg_wdata,
    // message words
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [71:0]                      i_s_axis_tdata,  // word_data[63:0], byte_count[67:64]
    input  logic                             i_s_axis_tlast,  // is_last
    // tags
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [63:0]                      o_m_axis_tdata   // hash_value[63:0]
);

    sip24_pkg::t_entry fe_entry;
    sip24_pkg::t_entry q_entry;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              accept;

    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && !q_full;

    sip24_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_word_data  (i_s_axis_tdata[63:0]),
        .i_byte_count (i_s_axis_tdata[67:64]),
        .i_is_last    (i_s_axis_tlast),
        .o_entry      (fe_entry)
    );

    sip24_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (fe_entry),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sip24_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_entry      (q_entry),
        .i_q_empty    (q_empty),
        .o_pop        (q_pop),
        .o_hash_valid (o_m_axis_tvalid),
        .i_hash_ready (i_m_axis_tready),
        .o_hash       (o_m_axis_tdata)
    );

endmodule

/* hw/rtl/sip24_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip24_front
// Accepts message words, tracks message position and length, and builds the
// padded length block for the last word.
// ----------------------------------------------------------------------------
module sip24_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [63:0]       i_word_data,
    input  logic [3:0]        i_byte_count,
    input  logic              i_is_last,
    output sip24_pkg::t_entry o_entry
);

    logic       r_mid;
    logic       n_mid;
    logic [7:0] r_len;
    logic [7:0] n_len;
    logic [3:0] cnt;
    logic [7:0] len_base;
    logic       last_full;
    logic [63:0] masked;

    // Clamp byte count, pick the running length, mask the unused data bytes
    always_comb begin
        cnt       = (i_byte_count > sip24_pkg::FULL_BYTES) ? sip24_pkg::FULL_BYTES
                                                           : i_byte_count;
        len_base  = r_mid ? r_len : 8'd0;
        last_full = (cnt == sip24_pkg::FULL_BYTES);
        masked    = i_word_data & ~(64'hffff_ffff_ffff_ffff << {cnt, 3'b000});
    end

    // Classification and length update
    always_comb begin
        o_entry.data = i_word_data;
        o_entry.load = !r_mid;
        if (!i_is_last) begin
            o_entry.full = 1'b1;
            o_entry.last = 1'b0;
            n_len        = len_base + 8'd8;
            o_entry.tail = '0;
            n_mid        = 1'b1;
        end else if (last_full) begin
            o_entry.full = 1'b1;
            o_entry.last = 1'b1;
            n_len        = len_base + 8'd8;
            o_entry.tail = {n_len, 56'd0};
            n_mid        = 1'b0;
        end else begin
            o_entry.full = 1'b0;
            o_entry.last = 1'b1;
            n_len        = len_base + {4'd0, cnt};
            o_entry.tail = {n_len, masked[55:0]};
            n_mid        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
            r_len <= 8'd0;
        end else if (i_accept) begin
            r_mid <= n_mid;
            r_len <= n_len;
        end
    end

endmodule

/* hw/rtl/sip24_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip24_queue
// Small FIFO of classified requests between front and back ends.
// ----------------------------------------------------------------------------
module sip24_queue #(
    parameter int unsigned DEPTH = sip24_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sip24_pkg::t_entry i_entry,
    input  logic              i_pop,
    output sip24_pkg::t_entry o_entry,
    output logic              o_full,
    output logic              o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sip24_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/sip24_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip24_back
// SipHash engine: one SipRound per cycle on four lanes unless a tag waits,
// absorbing queued requests and finalizing into a one-entry output register.
// ----------------------------------------------------------------------------
module sip24_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sip24_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [63:0]                        i_cfg_wdata,
    input  sip24_pkg::t_entry                  i_entry,
    input  logic                               i_q_empty,
    output logic                               o_pop,
    output logic                               o_hash_valid,
    input  logic                               i_hash_ready,
    output logic [63:0]                        o_hash
);

    sip24_pkg::t_be_state r_state;
    sip24_pkg::t_be_state n_state;
    sip24_pkg::t_lanes    r_v;
    sip24_pkg::t_lanes    n_v;
    sip24_pkg::t_lanes    base;
    sip24_pkg::t_lanes    rin;
    sip24_pkg::t_lanes    rout;
    logic [63:0]          r_msg;
    logic [63:0]          n_msg;
    logic [63:0]          r_tail;
    logic [63:0]          n_tail;
    logic                 r_tail_pend;
    logic                 n_tail_pend;
    logic                 r_is_tail;
    logic                 n_is_tail;
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    logic [63:0]          r_key_low;
    logic [63:0]          r_key_high;
    logic                 r_out_valid;
    logic [63:0]          r_out_data;
    logic                 out_free;
    logic                 out_load;
    logic [63:0]          m_in;

    assign out_free     = !r_out_valid || i_hash_ready;
    assign o_pop        = (r_state == sip24_pkg::BE_IDLE) && !i_q_empty;
    assign out_load     = (r_state == sip24_pkg::BE_FIN) && (r_cnt == sip24_pkg::FIN_LAST)
                          && out_free;
    assign o_hash_valid = r_out_valid;
    assign o_hash       = r_out_data;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == sip24_pkg::CFG_KEY_LOW) begin
                r_key_low <= i_cfg_wdata;
            end
            if (i_cfg_addr == sip24_pkg::CFG_KEY_HIGH) begin
                r_key_high <= i_cfg_wdata;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sip24_pkg::BE_IDLE: begin
                if (o_pop) begin
                    n_state = sip24_pkg::BE_ABS;
                end
            end
            sip24_pkg::BE_ABS: begin
                if (r_tail_pend) begin
                    n_state = sip24_pkg::BE_TAIL;
                end else if (r_is_tail) begin
                    n_state = sip24_pkg::BE_FIN;
                end else begin
                    n_state = sip24_pkg::BE_IDLE;
                end
            end
            sip24_pkg::BE_TAIL: n_state = sip24_pkg::BE_ABS;
            sip24_pkg::BE_FIN: begin
                if (out_load) begin
                    n_state = sip24_pkg::BE_IDLE;
                end
            end
            default: n_state = sip24_pkg::BE_IDLE;
        endcase
    end

    // Round input selection and lane update
    always_comb begin
        base        = i_entry.load ? sip24_pkg::key_lanes(r_key_low, r_key_high) : r_v;
        m_in        = i_entry.full ? i_entry.data : i_entry.tail;
        rin         = r_v;
        n_v         = r_v;
        n_msg       = r_msg;
        n_tail      = r_tail;
        n_tail_pend = r_tail_pend;
        n_is_tail   = r_is_tail;
        n_cnt       = r_cnt;
        unique case (r_state)
            sip24_pkg::BE_IDLE: begin
                rin   = base;
                rin.d = base.d ^ m_in;
            end
            sip24_pkg::BE_TAIL: begin
                rin.d = r_v.d ^ r_tail;
            end
            sip24_pkg::BE_FIN: begin
                if (r_cnt == 2'd0) begin
                    rin.c = r_v.c ^ sip24_pkg::FINAL_XOR;
                end
            end
            default: rin = r_v;
        endcase
        rout = sip24_pkg::sip_round(rin);
        unique case (r_state)
            sip24_pkg::BE_IDLE: begin
                if (o_pop) begin
                    n_v         = rout;
                    n_msg       = m_in;
                    n_tail      = i_entry.tail;
                    n_tail_pend = i_entry.last && i_entry.full;
                    n_is_tail   = i_entry.last && !i_entry.full;
                end
            end
            sip24_pkg::BE_ABS: begin
                n_v   = rout;
                n_v.a = rout.a ^ r_msg;
            end
            sip24_pkg::BE_TAIL: begin
                n_v         = rout;
                n_msg       = r_tail;
                n_tail_pend = 1'b0;
                n_is_tail   = 1'b1;
            end
            sip24_pkg::BE_FIN: begin
                if ((r_cnt != sip24_pkg::FIN_LAST) || out_free) begin
                    n_v   = rout;
                    n_cnt = r_cnt + 2'd1;
                end
            end
            default: n_v = r_v;
        endcase
    end

    // Lanes and message words
    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_msg  <= n_msg;
        r_tail <= n_tail;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sip24_pkg::BE_IDLE;
            r_tail_pend <= 1'b0;
            r_is_tail   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_tail_pend <= n_tail_pend;
            r_is_tail   <= n_is_tail;
            r_cnt       <= n_cnt;
        end
    end

    // Output register: loads the tag on the last finalization round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_hash_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= rout.a ^ rout.b ^ rout.c ^ rout.d;
        end
    end

    // Checks
    a_cnt_only_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sip24_pkg::BE_FIN) |-> (r_cnt == 2'd0))
        else $error("finalization counter active outside finalization");

    a_tail_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_tail_pend && r_is_tail))
        else $error("pending tail and tail absorb both set");

    a_fin_from_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sip24_pkg::BE_ABS && !r_tail_pend && r_is_tail)
        |=> (r_state == sip24_pkg::BE_FIN && r_cnt == 2'd0))
        else $error("tail absorb not followed by finalization");

    a_load_frees_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == sip24_pkg::BE_IDLE))
        else $error("tag load did not end finalization");

endmodule

/* tb/siphash_2_4_stream_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_2_4_stream_top_tb
// Self-checking bench for the streaming SipHash-2-4 hasher. Message words go
// in through the slave stream with random gaps; a local SipHash predictor
// computes each tag at the point of acceptance, and every tag on the master
// stream is checked against the oldest pending prediction. Covers directed
// corner cases, key changes at idle points, length wrap, random traffic and
// a long output hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module siphash_2_4_stream_top_tb;

    // SipHash initialization words
    localparam logic [63:0] INIT_A    = 64'h736f_6d65_7073_6575;
    localparam logic [63:0] INIT_B    = 64'h646f_7261_6e64_6f6d;
    localparam logic [63:0] INIT_C    = 64'h6c79_6765_6e65_7261;
    localparam logic [63:0] INIT_D    = 64'h7465_6462_7974_6573;
    localparam logic [63:0] FIN_MASK  = 64'h0000_0000_0000_00ff;
    localparam logic [63:0] ONES      = 64'hffff_ffff_ffff_ffff;

    localparam int unsigned RANDOM_ITEMS     = 1400;
    localparam int unsigned SETTLE_CYCLES    = 40;   // covers a last word's rounds, the queue and the tag register
    localparam int unsigned SINK_HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT      = 2000;

    // DUT signals
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [sip24_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [63:0] i_cfg_wdata     = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata  = '0;   // word_data[63:0], byte_count[67:64]
    logic        i_s_axis_tlast  = 1'b0; // is_last
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;         // hash_value[63:0]

    // Predictor state
    sip24_pkg::t_lanes hash_st;
    logic [7:0]        msg_len;
    bit                in_msg;
    logic [63:0]       key_lo;
    logic [63:0]       key_hi;
    logic [63:0]       tag_expect[$];

    // Bench bookkeeping
    int unsigned err_count     = 0;
    int unsigned items_sent    = 0;
    int unsigned stall_cycles  = 0;
    bit          no_gaps       = 1'b0;
    int unsigned sink_hold_ask  = 0;
    int unsigned sink_hold_seen = 0;
    int unsigned sink_hold_left = 0;
    int unsigned sink_gap_left  = 0;
    logic [63:0] tag_want;

    siphash_2_4_stream_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // SipHash predictor
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic sip24_pkg::t_lanes lane_round(input sip24_pkg::t_lanes v);
        v.a = v.a + v.b;
        v.b = rotl(v.b, 13) ^ v.a;
        v.a = rotl(v.a, 32);
        v.c = v.c + v.d;
        v.d = rotl(v.d, 16) ^ v.c;
        v.a = v.a + v.d;
        v.d = rotl(v.d, 21) ^ v.a;
        v.c = v.c + v.b;
        v.b = rotl(v.b, 17) ^ v.c;
        v.c = rotl(v.c, 32);
        return v;
    endfunction

    function automatic sip24_pkg::t_lanes compress(input sip24_pkg::t_lanes v,
                                                   input logic [63:0] m);
        v.d = v.d ^ m;
        v   = lane_round(lane_round(v));
        v.a = v.a ^ m;
        return v;
    endfunction

    function automatic void restart_lanes();
        hash_st.a = INIT_A ^ key_lo;
        hash_st.b = INIT_B ^ key_hi;
        hash_st.c = INIT_C ^ key_lo;
        hash_st.d = INIT_D ^ key_hi;
        msg_len   = 8'd0;
    endfunction

    // Advance the hash state by one accepted word; a last word queues a tag
    function automatic void predict_word(input logic [63:0] data, input logic [3:0] count,
                                         input bit last);
        logic [3:0]  n;
        logic [63:0] tail;
        n = (count > 4'd8) ? 4'd8 : count;
        if (!in_msg)
            restart_lanes();
        if (!last) begin
            hash_st = compress(hash_st, data);
            msg_len = msg_len + 8'd8;
            in_msg  = 1'b1;
            return;
        end
        if (n == 4'd8) begin
            hash_st = compress(hash_st, data);
            msg_len = msg_len + 8'd8;
            tail    = '0;
        end else begin
            tail    = data & ((64'd1 << (8 * n)) - 64'd1);
            msg_len = msg_len + {4'd0, n};
        end
        tail[63:56] = msg_len;
        hash_st     = compress(hash_st, tail);
        hash_st.c   = hash_st.c ^ FIN_MASK;
        repeat (4) hash_st = lane_round(hash_st);
        tag_expect.push_back(hash_st.a ^ hash_st.b ^ hash_st.c ^ hash_st.d);
        restart_lanes();
        in_msg = 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (err_count < 40)
            $display("MISMATCH at %0t: %s expected %h got %h", $realtime, what, want, got);
        err_count++;
    endtask

    // Tag checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (tag_expect.size() == 0) begin
                report_mismatch("unrequested tag", '0, o_m_axis_tdata);
            end else begin
                tag_want = tag_expect.pop_front();
                if (o_m_axis_tdata !== tag_want)
                    report_mismatch("hash_value", tag_want, o_m_axis_tdata);
            end
        end
    end

    // Output side: random stalls, plus a counted long hold on request
    always @(posedge i_clk) begin
        if (sink_hold_seen != sink_hold_ask) begin
            sink_hold_seen = sink_hold_ask;
            sink_hold_left = SINK_HOLD_CYCLES;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_gap_left > 0) begin
            sink_gap_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_gap_left = pick_gap();
        end
    end

    // Watchdog: nothing moving on either stream for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no traffic for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    // Offer one request after a random gap and wait until it is taken
    task automatic send_word(input logic [63:0] data, input logic [3:0] count, input bit last);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'd0, count, data};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_word(data, count, last);
        items_sent++;
    endtask

    // Stop offering, wait for every pending tag, then let the engine settle
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (tag_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both key halves; call only when idle
    task automatic write_keys(input logic [63:0] k0, input logic [63:0] k1);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= sip24_pkg::CFG_KEY_LOW;
        i_cfg_wdata <= k0;
        @(posedge i_clk);
        i_cfg_addr  <= sip24_pkg::CFG_KEY_HIGH;
        i_cfg_wdata <= k1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        key_lo = k0;
        key_hi = k1;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // One message of full words followed by a random last word
    task automatic send_message(input int unsigned full_words);
        logic [3:0] cnt;
        repeat (full_words) begin
            // a stray byte count on a middle word must be ignored
            cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            send_word(rand64(), cnt, 1'b0);
        end
        cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
        send_word(rand64(), cnt, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        // reset key: empty message, then a zero-count word with all bits set
        send_word(64'd0, 4'd0, 1'b1);
        send_word(ONES, 4'd0, 1'b1);
        drain();
        write_keys(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908);
        // full last word, then a 15-byte message
        send_word(64'h0706_0504_0302_0100, 4'd8, 1'b1);
        send_word(64'h0706_0504_0302_0100, 4'd8, 1'b0);
        send_word(64'h000e_0d0c_0b0a_0908, 4'd7, 1'b1);
        // middle words with odd byte counts, last counts above eight, then a 1-byte message
        send_word(ONES, 4'd0, 1'b0);
        send_word(ONES, 4'd5, 1'b0);
        send_word(ONES, 4'd15, 1'b1);
        send_word(64'h8000_0000_0000_0001, 4'd9, 1'b1);
        send_word(ONES, 4'd1, 1'b1);
        drain();
        write_keys(ONES, ONES);
        // key change in the middle of a message applies to the next one only
        send_word(64'h5555_aaaa_5555_aaaa, 4'd8, 1'b0);
        drain();
        write_keys(64'd0, ONES);
        send_word(64'hdead_beef_0bad_f00d, 4'd3, 1'b1);
        send_word(64'h0123_4567_89ab_cdef, 4'd4, 1'b1);
        drain();
        write_keys(ONES, 64'd0);
        send_word(64'd0, 4'd8, 1'b1);
        send_word(ONES, 4'd8, 1'b1);
        send_word(ONES, 4'd6, 1'b1);
        drain();
    endtask

    // Messages around and past 256 bytes so the length byte wraps
    task automatic test_length_wrap();
        write_keys(rand64(), rand64());
        send_message(31);
        send_message(32);
        send_message(33);
        send_message($urandom_range(34, 40));
        drain();
    endtask

    task automatic test_random_messages();
        int unsigned goal;
        int unsigned r;
        int unsigned msgs;
        goal = items_sent + RANDOM_ITEMS;
        for (int phase = 0; phase < 4; phase++) begin
            write_keys(rand64(), rand64());
            no_gaps = (phase == 2);
            msgs = 0;
            while (items_sent < goal - (3 - phase) * (RANDOM_ITEMS / 4)) begin
                r = $urandom_range(0, 9);
                if (r < 6)      send_message($urandom_range(0, 2));
                else if (r < 9) send_message($urandom_range(3, 6));
                else            send_message($urandom_range(7, 15));
                msgs++;
                // occasional full pause until all tags are back
                if (msgs % 40 == 0)
                    drain();
            end
            no_gaps = 1'b0;
            drain();
        end
    endtask

    // Hold the output off long enough for the block to stall its input
    task automatic test_output_backpressure();
        write_keys(rand64(), rand64());
        no_gaps = 1'b1;
        sink_hold_ask <= sink_hold_ask + 1;
        repeat (30) send_message($urandom_range(0, 1));
        no_gaps = 1'b0;
        drain();
    endtask

    initial begin
        key_lo = '0;
        key_hi = '0;
        restart_lanes();
        in_msg = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_length_wrap();
        test_random_messages();
        test_output_backpressure();
        drain();

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
